// File: rtl/core/qrm_pkg.sv
package qrm_pkg;

    // lanes: r11 r12 r13 r21 r22 r23 r31 r32 r33
    localparam int LANES   = 9;
    localparam int DW      = 16;            // component and entry width
    localparam int PW      = 32;            // product width
    localparam int NW      = 33;            // squared norm width
    localparam int RW      = NW + 1;        // partial remainder width
    localparam int QW      = 16;            // quotient bits, Q15 of |num|/n
    localparam int DIV_STEPS = QW;
    localparam logic signed [DW-1:0] ONE_Q14 = 16'sd16384;

    // registered squares and cross products
    typedef struct packed {
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] ww;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] zx;
        logic signed [PW-1:0] xw;
        logic signed [PW-1:0] yw;
        logic signed [PW-1:0] zw;
    } prod_t;

    // divider pipeline word
    typedef struct packed {
        logic [LANES-1:0][RW-1:0] rem;
        logic [LANES-1:0][QW-1:0] quo;
        logic [LANES-1:0]         neg;
        logic [NW-1:0]            den;
        logic                     zero;
    } div_t;

    // final matrix word
    typedef struct packed {
        logic [LANES-1:0][DW-1:0] ent;
        logic                     zero;
    } res_t;

endpackage

// File: rtl/core/qrm_quat_if.sv
interface qrm_quat_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   quat_x;
    logic signed [15:0]   quat_y;
    logic signed [15:0]   quat_z;
    logic signed [15:0]   quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// File: rtl/core/qrm_rot_if.sv
interface qrm_rot_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   r11;
    logic signed [15:0]   r12;
    logic signed [15:0]   r13;
    logic signed [15:0]   r21;
    logic signed [15:0]   r22;
    logic signed [15:0]   r23;
    logic signed [15:0]   r31;
    logic signed [15:0]   r32;
    logic signed [15:0]   r33;
    logic                 zero_norm;

    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    zero_norm, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    zero_norm, output ready);
endinterface

// File: rtl/core/qrm_front.sv
// Products, then norm and numerators, into the first divider word.
module qrm_front
(
    input  logic                         clk,
    input  logic                         en_prod,
    input  logic                         en_sum,
    input  logic signed [15:0]           x,
    input  logic signed [15:0]           y,
    input  logic signed [15:0]           z,
    input  logic signed [15:0]           w,
    output qrm_pkg::div_t                word
);
    localparam int SW = qrm_pkg::PW + 3;

    qrm_pkg::prod_t prod_reg, prod_next;
    qrm_pkg::div_t  word_reg, word_next;

    logic signed [SW-1:0] num [qrm_pkg::LANES];
    logic signed [SW-1:0] sq_x, sq_y, sq_z, sq_w;
    logic signed [SW-1:0] c_xy, c_yz, c_zx, c_xw, c_yw, c_zw;
    logic signed [SW-1:0] mag;
    logic        [SW-1:0] nrm;

    // stage 1: ten 16x16 products
    always_comb
    begin
        prod_next.xx = x * x;
        prod_next.yy = y * y;
        prod_next.zz = z * z;
        prod_next.ww = w * w;
        prod_next.xy = x * y;
        prod_next.yz = y * z;
        prod_next.zx = z * x;
        prod_next.xw = x * w;
        prod_next.yw = y * w;
        prod_next.zw = z * w;
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: norm, numerators, sign and magnitude
    always_comb
    begin
        sq_x = SW'(prod_reg.xx);
        sq_y = SW'(prod_reg.yy);
        sq_z = SW'(prod_reg.zz);
        sq_w = SW'(prod_reg.ww);
        c_xy = SW'(prod_reg.xy);
        c_yz = SW'(prod_reg.yz);
        c_zx = SW'(prod_reg.zx);
        c_xw = SW'(prod_reg.xw);
        c_yw = SW'(prod_reg.yw);
        c_zw = SW'(prod_reg.zw);
        nrm  = sq_x + sq_y + sq_z + sq_w;

        num[0] = sq_x + sq_w - sq_y - sq_z;
        num[1] = (c_xy + c_zw) <<< 1;
        num[2] = (c_zx - c_yw) <<< 1;
        num[3] = (c_xy - c_zw) <<< 1;
        num[4] = sq_y + sq_w - sq_x - sq_z;
        num[5] = (c_yz + c_xw) <<< 1;
        num[6] = (c_zx + c_yw) <<< 1;
        num[7] = (c_yz - c_xw) <<< 1;
        num[8] = sq_z + sq_w - sq_x - sq_y;

        word_next.den  = nrm[qrm_pkg::NW-1:0];
        word_next.zero = (nrm == '0);
        mag = '0;
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            mag = num[i][SW-1] ? -num[i] : num[i];
            word_next.neg[i] = num[i][SW-1];
            word_next.rem[i] = qrm_pkg::RW'(mag[qrm_pkg::NW-1:0]);
            word_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// File: rtl/core/qrm_div_step.sv
// One restoring division step for all nine lanes.
module qrm_div_step
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic          clk,
    input  logic          en,
    input  qrm_pkg::div_t din,
    output qrm_pkg::div_t dout
);
    qrm_pkg::div_t word_reg, word_next;

    logic [qrm_pkg::RW-1:0] trial;
    logic [qrm_pkg::RW-1:0] dvs;
    logic                   ge;

    always_comb
    begin
        word_next = din;
        dvs   = qrm_pkg::RW'(din.den);
        trial = '0;
        ge    = 1'b0;
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            // top quotient bit compares unshifted, later ones shift in a zero
            trial = FIRST ? din.rem[i] : {din.rem[i][qrm_pkg::RW-2:0], 1'b0};
            ge    = (trial >= dvs);
            word_next.rem[i] = ge ? trial - dvs : trial;
            word_next.quo[i] = {din.quo[i][qrm_pkg::QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

// File: rtl/core/qrm_round.sv
// Round Q15 ratio to Q14, apply sign, pick identity on a zero norm.
module qrm_round
(
    input  logic          clk,
    input  logic          en,
    input  qrm_pkg::div_t din,
    output qrm_pkg::res_t dout
);
    qrm_pkg::res_t res_reg, res_next;

    logic [qrm_pkg::QW:0]   qsum;
    logic [qrm_pkg::DW-1:0] qr;

    always_comb
    begin
        res_next.zero = din.zero;
        qsum = '0;
        qr   = '0;
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            // half-up on the magnitude gives ties away from zero
            qsum = {1'b0, din.quo[i]} + (qrm_pkg::QW+1)'(1);
            qr   = qsum[qrm_pkg::QW:1];
            if (din.zero)
            begin
                res_next.ent[i] = (i % 4 == 0) ? qrm_pkg::ONE_Q14 : '0;
            end
            else
            begin
                res_next.ent[i] = din.neg[i] ? -qr : qr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign dout = res_reg;

endmodule

// File: rtl/core/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, Q1.15 in, Q2.14 out.
// Throughput: one word per cycle while rot.ready stays high; each stage
// stalls only when full. One pipeline stage per quotient bit of the nine
// parallel 16-step restoring dividers, plus product, sum and rounding stages.
// Reset: rst_n clears all stage valid bits asynchronously; data is not reset.
module quaternion_to_rotation_matrix
(
    input  logic       clk,
    input  logic       rst_n,
    qrm_quat_if.sink   quat,
    qrm_rot_if.source  rot
);
    localparam int STAGES = qrm_pkg::DIV_STEPS + 3;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] load;

    qrm_pkg::div_t word [qrm_pkg::DIV_STEPS+1];
    qrm_pkg::res_t res;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || rot.ready;
        for (int i = STAGES-2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = (i == 0) ? quat.valid : valid_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign quat.ready = load[0];

    qrm_front u_front
    (
        .clk     (clk),
        .en_prod (load[0]),
        .en_sum  (load[1]),
        .x       (quat.quat_x),
        .y       (quat.quat_y),
        .z       (quat.quat_z),
        .w       (quat.quat_w),
        .word    (word[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar s = 0; s < qrm_pkg::DIV_STEPS; s++)
    begin : g_div
        qrm_div_step #(.FIRST(s == 0)) u_step
        (
            .clk  (clk),
            .en   (load[s+2]),
            .din  (word[s]),
            .dout (word[s+1])
        );
    end

    qrm_round u_round
    (
        .clk  (clk),
        .en   (load[STAGES-1]),
        .din  (word[qrm_pkg::DIV_STEPS]),
        .dout (res)
    );

    assign rot.valid     = valid_reg[STAGES-1];
    assign rot.r11       = res.ent[0];
    assign rot.r12       = res.ent[1];
    assign rot.r13       = res.ent[2];
    assign rot.r21       = res.ent[3];
    assign rot.r22       = res.ent[4];
    assign rot.r23       = res.ent[5];
    assign rot.r31       = res.ent[6];
    assign rot.r32       = res.ent[7];
    assign rot.r33       = res.ent[8];
    assign rot.zero_norm = res.zero;

endmodule
